FILE: rtl/y2rgb_pkg.sv
// ----------------------------------------------------------------------------
// y2rgb_pkg
// Types, register indexes and BT.601 conversion helpers shared by the
// YUYV to RGB downscaler.
// ----------------------------------------------------------------------------
package y2rgb_pkg;

    // Configuration port
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE = 3'd4;

    // Register reset values
    localparam int SRC_WIDTH_RST  = 640;
    localparam int SRC_HEIGHT_RST = 480;
    localparam int DST_WIDTH_RST  = 640;
    localparam int DST_HEIGHT_RST = 480;

    // Output coordinate widths
    localparam int COL_OUT_W = 11;
    localparam int ROW_OUT_W = 11;

    // BT.601 coefficients, 8 fractional bits
    localparam logic signed [17:0] COEF_RV = 18'sd359;
    localparam logic signed [17:0] COEF_GU = 18'sd88;
    localparam logic signed [17:0] COEF_GV = 18'sd183;
    localparam logic signed [17:0] COEF_BU = 18'sd454;
    localparam logic signed [8:0]  CHROMA_OFS = 9'sd128;
    localparam logic signed [10:0] CHAN_MAX   = 11'sd255;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } rgb_t;

    // One output pixel request
    typedef struct packed {
        rgb_t                 color;
        logic [COL_OUT_W-1:0] col;
        logic [ROW_OUT_W-1:0] row;
        logic                 last_item;
        logic                 last_frame;
    } pix_t;

    function automatic logic [7:0] clamp_u8(input logic signed [10:0] x);
        logic [7:0] res;
        if (x < 11'sd0)
            res = 8'd0;
        else if (x > CHAN_MAX)
            res = 8'd255;
        else
            res = x[7:0];
        return res;
    endfunction

    // YUV to RGB for one pixel; gray mode copies luma to all channels
    function automatic rgb_t yuv_to_rgb(input logic [7:0] y, input logic [7:0] u,
                                        input logic [7:0] v, input logic color);
        logic signed [8:0]  uo;
        logic signed [8:0]  vo;
        logic signed [17:0] ue;
        logic signed [17:0] ve;
        logic signed [17:0] pr;
        logic signed [17:0] pg;
        logic signed [17:0] pb;
        logic signed [10:0] sy;
        logic signed [10:0] sr;
        logic signed [10:0] sg;
        logic signed [10:0] sb;
        rgb_t               res;
        uo = $signed({1'b0, u}) - CHROMA_OFS;
        vo = $signed({1'b0, v}) - CHROMA_OFS;
        ue = 18'(uo);
        ve = 18'(vo);
        pr = COEF_RV * ve;
        pg = COEF_GU * ue + COEF_GV * ve;
        pb = COEF_BU * ue;
        sy = $signed({3'b000, y});
        sr = 11'(pr >>> 8);
        sg = 11'(pg >>> 8);
        sb = 11'(pb >>> 8);
        if (color)
        begin
            res.red   = clamp_u8(sy + sr);
            res.green = clamp_u8(sy - sg);
            res.blue  = clamp_u8(sy + sb);
        end
        else
        begin
            res.red   = y;
            res.green = y;
            res.blue  = y;
        end
        return res;
    endfunction

endpackage

FILE: rtl/yuyv_to_rgb_downscaler.sv
// ----------------------------------------------------------------------------
// yuyv_to_rgb_downscaler
// Nearest-neighbor downscaler for a YUYV raster stream with BT.601 RGB output.
//
//   channel   handshake             payload
//   in        in_valid / in_stall   luma_even, chroma_u, luma_odd, chroma_v
//   out       out_valid / out_stall blue, green, red, dest_column, dest_row,
//                                   last_of_item, last_of_frame
//   cfg       cfg_valid / cfg_ready cfg_index, cfg_data (always ready)
//
// One YUYV word is taken per cycle when it yields at most one pixel and the
// output is not stalled; a word that keeps both pixels holds off the next word
// until its second pixel moves into the single output register. The pixels of
// a word pass through the pair stage, then the output register, even pixel first.
// Reset selects 640x480 to 640x480 in color; any register write restarts the
// frame. A stalled output still lets one word's pixels wait in the pair
// stage, after which in_stall rises.
// ----------------------------------------------------------------------------
module yuyv_to_rgb_downscaler
    import y2rgb_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input words
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           luma_even,
    input  logic [7:0]           chroma_u,
    input  logic [7:0]           luma_odd,
    input  logic [7:0]           chroma_v,
    // output pixels
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           blue,
    output logic [7:0]           green,
    output logic [7:0]           red,
    output logic [COL_OUT_W-1:0] dest_column,
    output logic [ROW_OUT_W-1:0] dest_row,
    output logic                 last_of_item,
    output logic                 last_of_frame,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int SW_W = $clog2(MAX_WIDTH + 1);
    localparam int SH_W = $clog2(MAX_HEIGHT + 1);
    localparam int SC_W = $clog2(MAX_WIDTH + 2);
    localparam int SR_W = $clog2(MAX_HEIGHT + 1);
    localparam int CA_W = $clog2(MAX_WIDTH * (MAX_WIDTH + 1) + 1);
    localparam int RA_W = $clog2(MAX_HEIGHT * (MAX_HEIGHT + 1) + 1);

    // effective sizes after reset (destination equals source)
    localparam int RST_SW = (SRC_WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : SRC_WIDTH_RST;
    localparam int RST_SH = (SRC_HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : SRC_HEIGHT_RST;
    localparam int RST_DW = (DST_WIDTH_RST > RST_SW) ? RST_SW : DST_WIDTH_RST;
    localparam int RST_DH = (DST_HEIGHT_RST > RST_SH) ? RST_SH : DST_HEIGHT_RST;

    // saturate source size to 1..MAX
    function automatic logic [SW_W-1:0] eff_w(input logic [CFG_W-1:0] v);
        logic [SW_W-1:0] res;
        if (v == '0)
            res = SW_W'(1);
        else if (32'(v) > MAX_WIDTH)
            res = SW_W'(MAX_WIDTH);
        else
            res = SW_W'(v);
        return res;
    endfunction

    function automatic logic [SH_W-1:0] eff_h(input logic [CFG_W-1:0] v);
        logic [SH_W-1:0] res;
        if (v == '0)
            res = SH_W'(1);
        else if (32'(v) > MAX_HEIGHT)
            res = SH_W'(MAX_HEIGHT);
        else
            res = SH_W'(v);
        return res;
    endfunction

    // saturate destination size to source size
    function automatic logic [SW_W-1:0] clip_w(input logic [CFG_W-1:0] d,
                                               input logic [SW_W-1:0] s);
        logic [SW_W-1:0] res;
        if (32'(d) > 32'(s))
            res = s;
        else
            res = SW_W'(d);
        return res;
    endfunction

    function automatic logic [SH_W-1:0] clip_h(input logic [CFG_W-1:0] d,
                                               input logic [SH_W-1:0] s);
        logic [SH_W-1:0] res;
        if (32'(d) > 32'(s))
            res = s;
        else
            res = SH_W'(d);
        return res;
    endfunction

    // configuration registers
    logic [CFG_W-1:0] src_w_reg, src_w_next;
    logic [CFG_W-1:0] src_h_reg, src_h_next;
    logic [CFG_W-1:0] dst_w_reg, dst_w_next;
    logic [CFG_W-1:0] dst_h_reg, dst_h_next;
    logic             color_reg, color_next;
    logic             cfg_hit;

    // position state
    logic [SC_W-1:0] scol_reg;
    logic [SR_W-1:0] srow_reg;
    logic [CA_W-1:0] cacc_reg;
    logic [CA_W-1:0] cbnd_reg;
    logic [RA_W-1:0] racc_reg;
    logic [RA_W-1:0] rbnd_reg;
    logic [SW_W-1:0] ocol_reg;
    logic [SH_W-1:0] orow_reg;

    // pair stage and output register
    pix_t       pair_reg [2];
    logic [1:0] pair_vld_reg;
    pix_t       out_reg;
    logic       out_vld_reg;

    logic [SW_W-1:0] sw, dw, sw_n, dw_n;
    logic [SH_W-1:0] sh, dh, sh_n, dh_n;

    logic            accept;
    logic            row_kept;
    logic            keep0, keep1;
    logic            odd_in;
    logic            row_end, frame_end;
    logic [CA_W-1:0] cacc1, cacc2, cbnd1, cbnd2;
    logic [SW_W-1:0] ocol1, ocol2;
    logic [SC_W:0]   scol2;
    logic [SR_W-1:0] srow1;
    logic [ROW_OUT_W-1:0] dest_row_val;
    logic            last_row;
    pix_t            res0, res1;

    logic            out_free;
    logic            move;
    logic [1:0]      pair_left;
    pix_t            pick;

    assign cfg_ready = 1'b1;

    // register write decode
    always_comb
    begin
        src_w_next = src_w_reg;
        src_h_next = src_h_reg;
        dst_w_next = dst_w_reg;
        dst_h_next = dst_h_reg;
        color_next = color_reg;
        cfg_hit    = 1'b0;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_SRC_WIDTH:
                begin
                    src_w_next = cfg_data;
                    cfg_hit    = 1'b1;
                end
                REG_SRC_HEIGHT:
                begin
                    src_h_next = cfg_data;
                    cfg_hit    = 1'b1;
                end
                REG_DST_WIDTH:
                begin
                    dst_w_next = cfg_data;
                    cfg_hit    = 1'b1;
                end
                REG_DST_HEIGHT:
                begin
                    dst_h_next = cfg_data;
                    cfg_hit    = 1'b1;
                end
                REG_COLOR_MODE:
                begin
                    color_next = cfg_data[0];
                    cfg_hit    = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    // effective sizes, current and after a write
    assign sw   = eff_w(src_w_reg);
    assign sh   = eff_h(src_h_reg);
    assign dw   = clip_w(dst_w_reg, sw);
    assign dh   = clip_h(dst_h_reg, sh);
    assign sw_n = eff_w(src_w_next);
    assign sh_n = eff_h(src_h_next);
    assign dw_n = clip_w(dst_w_next, sw_n);
    assign dh_n = clip_h(dst_h_next, sh_n);

    // output handoff from the pair stage
    assign out_free = !out_vld_reg || !out_stall;
    assign move     = out_free && (pair_vld_reg != 2'b00);
    assign pick     = pair_vld_reg[0] ? pair_reg[0] : pair_reg[1];

    always_comb
    begin
        if (move)
            pair_left = pair_vld_reg[0] ? {pair_vld_reg[1], 1'b0} : 2'b00;
        else
            pair_left = pair_vld_reg;
    end

    assign in_stall = (pair_left != 2'b00);
    assign accept   = in_valid && !in_stall;

    // pixel picks for the even and odd pixel
    assign row_kept = (orow_reg < dh) && (racc_reg < rbnd_reg);
    assign keep0    = row_kept && (ocol_reg < dw) && (cacc_reg < cbnd_reg);
    assign cacc1    = cacc_reg + (keep0 ? CA_W'(sw) : CA_W'(0));
    assign ocol1    = ocol_reg + SW_W'(keep0);
    assign cbnd1    = cbnd_reg + CA_W'(dw);
    assign odd_in   = ({1'b0, scol_reg} + (SC_W+1)'(1)) < (SC_W+1)'(sw);
    assign keep1    = odd_in && row_kept && (ocol1 < dw) && (cacc1 < cbnd1);
    assign cacc2    = cacc1 + (keep1 ? CA_W'(sw) : CA_W'(0));
    assign ocol2    = ocol1 + SW_W'(keep1);
    assign cbnd2    = cbnd1 + CA_W'(dw);

    assign scol2     = {1'b0, scol_reg} + (SC_W+1)'(2);
    assign row_end   = scol2 >= (SC_W+1)'(sw);
    assign srow1     = srow_reg + SR_W'(1);
    assign frame_end = 32'(srow1) >= 32'(sh);

    // result fields
    assign dest_row_val = ROW_OUT_W'(dh - SH_W'(1) - orow_reg);
    assign last_row     = (orow_reg == dh - SH_W'(1));

    always_comb
    begin
        res0.color      = yuv_to_rgb(luma_even, chroma_u, chroma_v, color_reg);
        res0.col        = COL_OUT_W'(ocol_reg);
        res0.row        = dest_row_val;
        res0.last_item  = !keep1;
        res0.last_frame = last_row && (ocol_reg == dw - SW_W'(1));
        res1.color      = yuv_to_rgb(luma_odd, chroma_u, chroma_v, color_reg);
        res1.col        = COL_OUT_W'(ocol1);
        res1.row        = dest_row_val;
        res1.last_item  = 1'b1;
        res1.last_frame = last_row && (ocol1 == dw - SW_W'(1));
    end

    // configuration and position state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_w_reg <= CFG_W'(SRC_WIDTH_RST);
            src_h_reg <= CFG_W'(SRC_HEIGHT_RST);
            dst_w_reg <= CFG_W'(DST_WIDTH_RST);
            dst_h_reg <= CFG_W'(DST_HEIGHT_RST);
            color_reg <= 1'b1;
            scol_reg  <= '0;
            srow_reg  <= '0;
            cacc_reg  <= '0;
            cbnd_reg  <= CA_W'(RST_DW);
            racc_reg  <= '0;
            rbnd_reg  <= RA_W'(RST_DH);
            ocol_reg  <= '0;
            orow_reg  <= '0;
        end
        else
        begin
            src_w_reg <= src_w_next;
            src_h_reg <= src_h_next;
            dst_w_reg <= dst_w_next;
            dst_h_reg <= dst_h_next;
            color_reg <= color_next;
            if (cfg_hit)
            begin
                // every write restarts the frame under the new sizes
                scol_reg <= '0;
                srow_reg <= '0;
                cacc_reg <= '0;
                cbnd_reg <= CA_W'(dw_n);
                racc_reg <= '0;
                rbnd_reg <= RA_W'(dh_n);
                ocol_reg <= '0;
                orow_reg <= '0;
            end
            else if (accept)
            begin
                if (!row_end)
                begin
                    scol_reg <= SC_W'(scol2);
                    cacc_reg <= cacc2;
                    cbnd_reg <= cbnd2;
                    ocol_reg <= ocol2;
                end
                else
                begin
                    // restart the row
                    scol_reg <= '0;
                    cacc_reg <= '0;
                    cbnd_reg <= CA_W'(dw);
                    ocol_reg <= '0;
                    if (frame_end)
                    begin
                        srow_reg <= '0;
                        racc_reg <= '0;
                        rbnd_reg <= RA_W'(dh);
                        orow_reg <= '0;
                    end
                    else
                    begin
                        srow_reg <= srow1;
                        rbnd_reg <= rbnd_reg + RA_W'(dh);
                        if (row_kept)
                        begin
                            orow_reg <= orow_reg + SH_W'(1);
                            racc_reg <= racc_reg + RA_W'(sh);
                        end
                    end
                end
            end
        end
    end

    // valid flags of the pair stage and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_vld_reg <= 2'b00;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            pair_vld_reg <= accept ? {keep1, keep0} : pair_left;
            if (move)
                out_vld_reg <= 1'b1;
            else if (!out_stall)
                out_vld_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pair_reg[0] <= res0;
            pair_reg[1] <= res1;
        end
        if (move)
            out_reg <= pick;
    end

    assign out_valid     = out_vld_reg;
    assign blue          = out_reg.color.blue;
    assign green         = out_reg.color.green;
    assign red           = out_reg.color.red;
    assign dest_column   = out_reg.col;
    assign dest_row      = out_reg.row;
    assign last_of_item  = out_reg.last_item;
    assign last_of_frame = out_reg.last_frame;

endmodule
